>>> src/window_distinct_checker_unit_assert.svh
// Assertion macros shared by the window distinct checker modules
`ifndef WINDOW_DISTINCT_CHECKER_UNIT_ASSERT_SVH
`define WINDOW_DISTINCT_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define WDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/wdc_pkg.sv
// Shared types and constants for the window distinct checker
package wdc_pkg;

   localparam int POS_W = 11;
   localparam int VAL_W = 10;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             inc;
      logic [VAL_W-1:0] value;
   } cnt_op_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } cnt_status_type;

endpackage

>>> src/wdc_channel_if.sv
// Request and response channel interfaces for the window distinct checker
interface wdc_req_if;
   import wdc_pkg::*;
   logic             valid;
   logic             ready;
   logic             mode;
   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] element_value;
   logic [POS_W-1:0] range_left;
   logic [POS_W-1:0] range_right;

   modport source (output valid, mode, position, element_value, range_left, range_right,
                   input ready);
   modport sink (input valid, mode, position, element_value, range_left, range_right,
                 output ready);
endinterface

interface wdc_rsp_if;
   logic valid;
   logic ready;
   logic all_distinct;
   logic bad_query;

   modport source (output valid, all_distinct, bad_query, input ready);
   modport sink (input valid, all_distinct, bad_query, output ready);
endinterface

>>> src/wdc_elem_ram.sv
// Single-port read-first element store with registered read data
module wdc_elem_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff <= mem_ff[addr];
         if (we) begin
            mem_ff[addr] <= wdata;
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/wdc_count_unit.sv
// Occurrence count memory with read-modify-write pipeline, forwarding and clear pass
`include "window_distinct_checker_unit_assert.svh"

module wdc_count_unit #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_RANGE  = 1024,
   localparam int CNW = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wdc_pkg::cnt_op_type     op,
   output wdc_pkg::cnt_status_type status,
   output logic [CNW-1:0]          distinct_total
);
   import wdc_pkg::*;

   localparam int VW = $clog2(VALUE_RANGE);
   localparam logic [VW-1:0] CLR_LAST = VW'(VALUE_RANGE - 1);

   logic [CNW-1:0] mem_ff [VALUE_RANGE];
   logic [CNW-1:0] rd_data_ff;
   cnt_op_type     s1_ff;
   logic           fwd_valid_ff;
   logic [VW-1:0]  fwd_addr_ff;
   logic [CNW-1:0] fwd_data_ff;
   logic           clr_ff;
   logic [VW-1:0]  clr_idx_ff;
   logic [CNW-1:0] total_ff;
   logic [CNW-1:0] total_in;
   logic [VW-1:0]  rd_addr;
   logic [VW-1:0]  s1_addr;
   logic [CNW-1:0] old_cnt;
   logic [CNW-1:0] new_cnt;
   logic           wr_en;
   logic [VW-1:0]  wr_addr;
   logic [CNW-1:0] wr_data;

   assign rd_addr = VW'(op.value);
   assign s1_addr = VW'(s1_ff.value);
   assign old_cnt = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff : rd_data_ff;

   always_comb begin
      if (s1_ff.inc) begin
         new_cnt = old_cnt + CNW'(1);
      end else if (old_cnt == '0) begin
         new_cnt = old_cnt;
      end else begin
         new_cnt = old_cnt - CNW'(1);
      end
   end

   always_comb begin
      total_in = total_ff;
      if (s1_ff.valid) begin
         if (s1_ff.inc && (old_cnt == '0)) begin
            total_in = total_ff + CNW'(1);
         end else if (!s1_ff.inc && (old_cnt == CNW'(1))) begin
            total_in = total_ff - CNW'(1);
         end
      end
   end

   always_comb begin
      wr_en   = clr_ff || s1_ff.valid;
      wr_addr = clr_ff ? clr_idx_ff : s1_addr;
      wr_data = clr_ff ? '0 : new_cnt;
   end

   always_ff @(posedge clock) begin
      if (op.valid) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      fwd_addr_ff <= s1_addr;
      fwd_data_ff <= new_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         fwd_valid_ff <= 1'b0;
         clr_ff       <= 1'b1;
         clr_idx_ff   <= '0;
         total_ff     <= '0;
      end else begin
         s1_ff        <= op;
         fwd_valid_ff <= s1_ff.valid;
         total_ff     <= total_in;
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + VW'(1);
            if (clr_idx_ff == CLR_LAST) begin
               clr_ff <= 1'b0;
            end
         end
      end
   end

   assign status.clearing = clr_ff;
   assign status.busy     = s1_ff.valid;
   assign distinct_total  = total_ff;

   `WDC_ASSERT_NOW(a_no_op_while_clearing, clock, reset, op.valid, !clr_ff, "count op during clear")
   `WDC_ASSERT_NEXT(a_clear_ends, clock, reset, clr_ff && (clr_idx_ff == CLR_LAST), !clr_ff, "clear pass overran")
   `WDC_ASSERT_NEXT(a_first_rise, clock, reset, s1_ff.valid && s1_ff.inc && (old_cnt == '0), total_ff == $past(total_ff) + CNW'(1), "distinct total missed a new value")

endmodule

>>> src/window_distinct_checker_unit.sv
// Top level of the window distinct checker: request sequencer and window walk
// Load: the element is written at once when outside the window; when the loaded position
// is inside it, ST_LDEC removes the old value and ST_LADD adds the new one. Query: the window
// walk moves one edge per cycle through the count memory read-modify-write pipeline, then
// ST_DONE answers; a rejected query goes straight to ST_DONE. Reset: synchronous; a clearing
// pass over all VALUE_RANGE entries zeroes the count memory, and no request is accepted until it ends.
`include "window_distinct_checker_unit_assert.svh"

module window_distinct_checker_unit #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_RANGE  = 1024
) (
   input logic        clock,
   input logic        reset,
   wdc_req_if.sink    req_chan,
   wdc_rsp_if.source  rsp_chan
);
   import wdc_pkg::*;

   localparam int AW    = $clog2(MAX_ELEMENTS);
   localparam int CNW   = $clog2(MAX_ELEMENTS + 1);
   localparam int MEXT  = (CNW > POS_W) ? CNW : POS_W;
   localparam int VRW   = $clog2(VALUE_RANGE + 1);
   localparam int VEXT  = (VRW > VAL_W) ? VRW : VAL_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_LDEC  = 3'd3;
   localparam logic [2:0] ST_LADD  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [POS_W-1:0] lo_ff, lo_in;
   logic [POS_W-1:0] hi_ff, hi_in;
   logic [POS_W-1:0] left_ff;
   logic [POS_W-1:0] right_ff;
   logic             bad_ff;
   logic [VAL_W-1:0] ld_value_ff;
   logic             pend_valid_ff, pend_valid_in;
   logic             pend_inc_ff, pend_inc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_distinct_ff;
   logic             rsp_bad_ff;
   logic             rsp_set;

   logic             req_fire;
   logic             ld_ok;
   logic             ld_in_win;
   logic             q_bad;
   logic             drained;
   logic [POS_W-1:0] q_len;

   logic             elem_en;
   logic             elem_we;
   logic [AW-1:0]    elem_addr;
   logic [VAL_W-1:0] elem_rdata;

   cnt_op_type       cnt_op;
   cnt_status_type   cnt_status;
   logic [CNW-1:0]   distinct_total;

   wdc_elem_ram #(
      .DEPTH (MAX_ELEMENTS),
      .WIDTH (VAL_W)
   ) u_elem_ram (
      .clock (clock),
      .en    (elem_en),
      .we    (elem_we),
      .addr  (elem_addr),
      .wdata (req_chan.element_value),
      .rdata (elem_rdata)
   );

   wdc_count_unit #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_RANGE  (VALUE_RANGE)
   ) u_count_unit (
      .clock          (clock),
      .reset          (reset),
      .op             (cnt_op),
      .status         (cnt_status),
      .distinct_total (distinct_total)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign ld_ok = (req_chan.position != '0)
               && (MEXT'(req_chan.position) <= MEXT'(MAX_ELEMENTS))
               && (VEXT'(req_chan.element_value) < VEXT'(VALUE_RANGE));
   assign ld_in_win = (req_chan.position >= lo_ff) && (req_chan.position <= hi_ff);
   assign q_bad = (req_chan.range_left > req_chan.range_right)
               || (req_chan.range_left == '0)
               || (MEXT'(req_chan.range_right) > MEXT'(MAX_ELEMENTS));

   assign drained = !pend_valid_ff && !cnt_status.busy;
   assign q_len   = right_ff - left_ff + POS_W'(1);

   always_comb begin
      cnt_op.valid = pend_valid_ff || (state_ff == ST_LADD);
      cnt_op.inc   = pend_valid_ff ? pend_inc_ff : 1'b1;
      cnt_op.value = pend_valid_ff ? elem_rdata : ld_value_ff;
   end

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      elem_en       = 1'b0;
      elem_we       = 1'b0;
      elem_addr     = '0;
      pend_valid_in = 1'b0;
      pend_inc_in   = 1'b0;
      rsp_set       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_CLEAR: begin
            if (!cnt_status.clearing) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.mode == MODE_LOAD) begin
                  if (ld_ok) begin
                     elem_en   = 1'b1;
                     elem_we   = 1'b1;
                     elem_addr = AW'(req_chan.position - POS_W'(1));
                     if (ld_in_win) begin
                        pend_valid_in = 1'b1;
                        state_in      = ST_LDEC;
                     end
                  end
               end else begin
                  state_in = q_bad ? ST_DONE : ST_WALK;
               end
            end
         end
         ST_LDEC: begin
            state_in = ST_LADD;
         end
         ST_LADD: begin
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (hi_ff < right_ff) begin
               elem_en       = 1'b1;
               elem_addr     = AW'(hi_ff);
               pend_valid_in = 1'b1;
               pend_inc_in   = 1'b1;
               hi_in         = hi_ff + POS_W'(1);
            end else if (lo_ff > left_ff) begin
               elem_en       = 1'b1;
               elem_addr     = AW'(lo_ff - POS_W'(2));
               pend_valid_in = 1'b1;
               pend_inc_in   = 1'b1;
               lo_in         = lo_ff - POS_W'(1);
            end else if (hi_ff > right_ff) begin
               elem_en       = 1'b1;
               elem_addr     = AW'(hi_ff - POS_W'(1));
               pend_valid_in = 1'b1;
               hi_in         = hi_ff - POS_W'(1);
            end else if (lo_ff < left_ff) begin
               elem_en       = 1'b1;
               elem_addr     = AW'(lo_ff - POS_W'(1));
               pend_valid_in = 1'b1;
               lo_in         = lo_ff + POS_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (drained && (!rsp_valid_ff || rsp_chan.ready)) begin
               rsp_set  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         lo_ff         <= POS_W'(1);
         hi_ff         <= '0;
         pend_valid_ff <= 1'b0;
         pend_inc_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         pend_valid_ff <= pend_valid_in;
         pend_inc_ff   <= pend_inc_in;
         rsp_valid_ff  <= rsp_set || rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff     <= req_chan.range_left;
         right_ff    <= req_chan.range_right;
         bad_ff      <= q_bad;
         ld_value_ff <= req_chan.element_value;
      end
      if (rsp_set) begin
         rsp_bad_ff      <= bad_ff;
         rsp_distinct_ff <= !bad_ff && (MEXT'(distinct_total) == MEXT'(q_len));
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.all_distinct = rsp_distinct_ff;
   assign rsp_chan.bad_query    = rsp_bad_ff;

   `WDC_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "response raised outside completion")
   `WDC_ASSERT_NOW(a_window_order, clock, reset, 1'b1, {1'b0, lo_ff} <= ({1'b0, hi_ff} + (POS_W + 1)'(1)), "window edges crossed")
   `WDC_ASSERT_NOW(a_walk_after_clear, clock, reset, state_ff == ST_WALK, !cnt_status.clearing, "window walk during clear pass")

endmodule

>>> tb/window_distinct_checker_unit_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the window distinct checker: tracks the window and checks responses
module window_distinct_checker_unit_scoreboard #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_RANGE  = 1024
) (
   input  logic clock,
   input  logic reset,
   wdc_req_if   req_chan,
   wdc_rsp_if   rsp_chan,
   output int   mismatch_count,
   output int   pending_count
);
   import wdc_pkg::*;

   typedef struct packed {
      logic all_distinct;
      logic bad_query;
   } answer_type;

   logic [VAL_W-1:0] element_copy [1:MAX_ELEMENTS] = '{default: '0};
   int unsigned      occurrence [0:VALUE_RANGE-1] = '{default: 0};
   int unsigned      distinct_seen = 0;
   int unsigned      span_lo = 1;
   int unsigned      span_hi = 0;
   answer_type       answer_q [$];
   int               error_total = 0;

   task automatic add_occurrence(input logic [VAL_W-1:0] value);
      occurrence[value]++;
      if (occurrence[value] == 1) distinct_seen++;
   endtask

   task automatic drop_occurrence(input logic [VAL_W-1:0] value);
      if (occurrence[value] != 0) begin
         occurrence[value]--;
         if (occurrence[value] == 0) distinct_seen--;
      end
   endtask

   task automatic store_element(input logic [POS_W-1:0] position,
                                input logic [VAL_W-1:0] value);
      int unsigned slot;
      slot = int'(position);
      if (slot < 1 || slot > MAX_ELEMENTS || int'(value) >= VALUE_RANGE) return;
      if (slot >= span_lo && slot <= span_hi) begin
         drop_occurrence(element_copy[slot]);
         add_occurrence(value);
      end
      element_copy[slot] = value;
   endtask

   task automatic resolve_range(input logic [POS_W-1:0] range_left,
                                input logic [POS_W-1:0] range_right,
                                output answer_type answer);
      int unsigned left;
      int unsigned right;
      left  = int'(range_left);
      right = int'(range_right);
      if (left > right || left < 1 || right > MAX_ELEMENTS) begin
         answer.all_distinct = 1'b0;
         answer.bad_query    = 1'b1;
         return;
      end
      // grow first, then shrink
      while (span_hi < right) begin
         span_hi++;
         add_occurrence(element_copy[span_hi]);
      end
      while (span_lo > left) begin
         span_lo--;
         add_occurrence(element_copy[span_lo]);
      end
      while (span_hi > right) begin
         drop_occurrence(element_copy[span_hi]);
         span_hi--;
      end
      while (span_lo < left) begin
         drop_occurrence(element_copy[span_lo]);
         span_lo++;
      end
      answer.all_distinct = (distinct_seen == right - left + 1);
      answer.bad_query    = 1'b0;
   endtask

   task automatic note_mismatch(input string field, input logic expected, input logic actual);
      error_total++;
      if (error_total <= 10)
         $display("%0t: %s mismatch: expected %b, got %b", $realtime, field, expected, actual);
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.mode == MODE_LOAD) begin
               store_element(req_chan.position, req_chan.element_value);
            end else begin
               resolve_range(req_chan.range_left, req_chan.range_right, want);
               answer_q.push_back(want);
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (answer_q.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: response with no query outstanding (all_distinct %b, bad_query %b)",
                           $realtime, rsp_chan.all_distinct, rsp_chan.bad_query);
            end else begin
               want = answer_q.pop_front();
               if (rsp_chan.all_distinct !== want.all_distinct)
                  note_mismatch("all_distinct", want.all_distinct, rsp_chan.all_distinct);
               if (rsp_chan.bad_query !== want.bad_query)
                  note_mismatch("bad_query", want.bad_query, rsp_chan.bad_query);
            end
         end
      end
      mismatch_count <= error_total;
      pending_count  <= answer_q.size();
   end

endmodule

>>> tb/window_distinct_checker_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the window distinct checker: clock, reset, request stimulus and verdict
module window_distinct_checker_unit_tb;
   import wdc_pkg::*;

   localparam int MAX_ELEMENTS  = 1024;
   localparam int VALUE_RANGE   = 1024;
   localparam int POS_TOP       = (1 << POS_W) - 1;
   localparam int RANDOM_ITEMS  = 560;
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 16;
   localparam int unsigned PRESET_VALUES [8] = '{0, 1023, 5, 5, 7, 0, 1023, 3};

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   stall_cycles = 0;
   bit   no_idle = 1'b0;
   bit   loaded [1:MAX_ELEMENTS];
   int unsigned loaded_top = 0;
   int   load_total = 0;
   int   ignored_loads = 0;
   int   query_total = 0;
   int   rejected_queries = 0;

   wdc_req_if req_chan ();
   wdc_rsp_if rsp_chan ();

   window_distinct_checker_unit #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .VALUE_RANGE (VALUE_RANGE)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   window_distinct_checker_unit_scoreboard #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .VALUE_RANGE (VALUE_RANGE)
   ) i_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= no_idle || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("window_distinct_checker_unit_tb NOT OK");
      $finish;
   end

   function automatic int unsigned pick_value();
      if ($urandom_range(1) == 1) return $urandom_range(15);
      return $urandom_range(VALUE_RANGE - 1);
   endfunction

   task automatic send_request(input logic mode, input logic [POS_W-1:0] position,
                               input logic [VAL_W-1:0] value,
                               input logic [POS_W-1:0] range_left,
                               input logic [POS_W-1:0] range_right);
      if (!no_idle) begin
         while ($urandom_range(99) < 33) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid         <= 1'b1;
      req_chan.mode          <= mode;
      req_chan.position      <= position;
      req_chan.element_value <= value;
      req_chan.range_left    <= range_left;
      req_chan.range_right   <= range_right;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic load_element(input int unsigned position, input int unsigned value);
      send_request(MODE_LOAD, POS_W'(position), VAL_W'(value),
                   POS_W'($urandom_range(POS_TOP)), POS_W'($urandom_range(POS_TOP)));
      if (position >= 1 && position <= MAX_ELEMENTS) begin
         load_total++;
         loaded[position] = 1'b1;
         while (loaded_top < MAX_ELEMENTS && loaded[loaded_top + 1]) loaded_top++;
      end else begin
         ignored_loads++;
      end
   endtask

   task automatic ask_range(input int unsigned range_left, input int unsigned range_right);
      send_request(MODE_QUERY, POS_W'($urandom_range(POS_TOP)),
                   VAL_W'($urandom_range(VALUE_RANGE - 1)),
                   POS_W'(range_left), POS_W'(range_right));
      query_total++;
      if (range_left > range_right || range_left < 1 || range_right > MAX_ELEMENTS)
         rejected_queries++;
   endtask

   // hold the sender until every outstanding answer is back
   task automatic drain_answers();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int unsigned roll;
      int unsigned position;
      int unsigned left;
      int unsigned span;
      roll = $urandom_range(99);
      if (roll < 6) begin
         if ($urandom_range(1) == 1) position = 0;
         else position = $urandom_range(MAX_ELEMENTS + 1, POS_TOP);
         load_element(position, pick_value());
      end else if (roll < 12) begin
         case ($urandom_range(2))
            0: begin
               left = $urandom_range(2, MAX_ELEMENTS);
               ask_range(left, $urandom_range(1, left - 1));
            end
            1: ask_range(0, $urandom_range(POS_TOP));
            default: ask_range($urandom_range(POS_TOP), $urandom_range(MAX_ELEMENTS + 1, POS_TOP));
         endcase
      end else if (roll < 40 || loaded_top == 0) begin
         if (loaded_top < MAX_ELEMENTS && (loaded_top == 0 || $urandom_range(99) < 60))
            position = loaded_top + 1;
         else if ($urandom_range(9) == 0)
            position = $urandom_range(1, MAX_ELEMENTS);
         else
            position = $urandom_range(1, loaded_top);
         load_element(position, pick_value());
      end else begin
         // stay inside the loaded prefix
         if ($urandom_range(4) != 0)
            span = $urandom_range(1, (loaded_top < 12) ? loaded_top : 12);
         else
            span = $urandom_range(1, loaded_top);
         left = $urandom_range(1, loaded_top - span + 1);
         ask_range(left, left + span - 1);
      end
   endtask

   initial begin
      int unsigned left;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.mode          <= MODE_LOAD;
      req_chan.position      <= '0;
      req_chan.element_value <= '0;
      req_chan.range_left    <= '0;
      req_chan.range_right   <= '0;
      for (int i = 1; i <= MAX_ELEMENTS; i++) loaded[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      load_element(0, VALUE_RANGE - 1);
      load_element(POS_TOP, 0);
      load_element(MAX_ELEMENTS + 1, 512);
      load_element(MAX_ELEMENTS, VALUE_RANGE - 1);
      ask_range(5, 4);
      ask_range(0, 0);
      ask_range(1, POS_TOP);
      ask_range(MAX_ELEMENTS, MAX_ELEMENTS - 1);
      for (int i = 0; i < 8; i++) load_element(i + 1, PRESET_VALUES[i]);
      ask_range(1, 1);
      ask_range(1, 2);
      ask_range(3, 4);
      ask_range(2, 8);
      ask_range(5, 8);
      ask_range(8, 8);
      ask_range(1, 8);
      load_element(4, 9);
      ask_range(3, 6);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         no_idle <= (i >= 200 && i < 330);
         if (i == 150 || i == 450) drain_answers();
         random_request();
      end
      no_idle <= 1'b0;

      // close with queries within the loaded prefix, starting with the whole of it
      drain_answers();
      ask_range(1, loaded_top);
      ask_range(loaded_top, loaded_top);
      for (int i = 0; i < 20; i++) begin
         left = $urandom_range(1, loaded_top);
         ask_range(left, $urandom_range(left, loaded_top));
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d loads stored, %0d out-of-range loads, %0d queries (%0d rejected)",
               load_total, ignored_loads, query_total, rejected_queries);
      $display("Summary: array filled up to position %0d, %0d mismatches",
               loaded_top, mismatch_count);
      if (mismatch_count == 0)
         $display("window_distinct_checker_unit_tb OK");
      else
         $display("window_distinct_checker_unit_tb NOT OK");
      $finish;
   end

endmodule
